[rtl/lpm_pkg.sv]
// shared types and constants for the longest prefix match lookup
// no dependencies; used by every module under rtl
package lpm_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PORT_COUNT      = 16;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 4;
    localparam int SLOT_W = 4;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [PORT_W-1:0] port;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [SLOT_W-1:0] slot;
        logic [PORT_W-1:0] port;
        logic              found;
    } result_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic load_out;
        logic busy;
    } scan_ctrl_t;

endpackage

[rtl/lpm_table.sv]
// route table storage: valid flags in flops, entry fields in a memory
// depends on lpm_pkg
module lpm_table #(
    parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_slot,
    input  logic                      wr_valid,
    input  logic [lpm_pkg::ADDR_W-1:0] wr_prefix,
    input  logic [lpm_pkg::ADDR_W-1:0] wr_mask,
    input  logic [lpm_pkg::PORT_W-1:0] wr_port,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic                      rd_strobe,
    output logic [IDX_W-1:0]          rd_slot,
    output lpm_pkg::entry_t           rd_entry
);
    import lpm_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]      prefix_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]      mask_mem   [TABLE_DEPTH];
    logic [PORT_W-1:0]      port_mem   [TABLE_DEPTH];

    logic [ADDR_W-1:0] rd_prefix_reg;
    logic [ADDR_W-1:0] rd_mask_reg;
    logic [PORT_W-1:0] rd_port_reg;
    logic              rd_vld_reg;
    logic              rd_strobe_reg;
    logic [IDX_W-1:0]  rd_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_strobe_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_slot] <= wr_valid;
            end
            rd_strobe_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_slot] <= wr_prefix;
            mask_mem[wr_slot]   <= wr_mask;
            port_mem[wr_slot]   <= wr_port;
        end
        if (rd_en)
        begin
            rd_prefix_reg <= prefix_mem[rd_addr];
            rd_mask_reg   <= mask_mem[rd_addr];
            rd_port_reg   <= port_mem[rd_addr];
            rd_vld_reg    <= valid_reg[rd_addr];
            rd_slot_reg   <= rd_addr;
        end
    end

    assign rd_strobe       = rd_strobe_reg;
    assign rd_slot         = rd_slot_reg;
    assign rd_entry.vld    = rd_vld_reg;
    assign rd_entry.prefix = rd_prefix_reg;
    assign rd_entry.mask   = rd_mask_reg;
    assign rd_entry.port   = rd_port_reg;

endmodule

[rtl/lpm_best.sv]
// shared match and compare unit, keeps the best entry seen in a scan
// depends on lpm_pkg
module lpm_best #(
    parameter int IDX_W = 4
) (
    input  logic                       clk,
    input  logic                       clear,
    input  logic [lpm_pkg::ADDR_W-1:0] lookup_address,
    input  logic                       rd_strobe,
    input  logic [IDX_W-1:0]           rd_slot,
    input  lpm_pkg::entry_t            rd_entry,
    output lpm_pkg::result_t           best
);
    import lpm_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    result_t           best_reg;
    logic              match;
    logic              better;

    assign match  = ((rd_entry.prefix ^ addr_reg) & rd_entry.mask) == '0;
    // first hit always wins, later ones only with a strictly larger mask
    assign better = !best_reg.found || (rd_entry.mask > best_reg.mask);

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            addr_reg <= lookup_address;
            best_reg <= '0;
        end
        else if (rd_strobe && rd_entry.vld && match && better)
        begin
            best_reg.found <= 1'b1;
            best_reg.port  <= rd_entry.port;
            best_reg.slot  <= SLOT_W'(rd_slot);
            best_reg.mask  <= rd_entry.mask;
        end
    end

    assign best = best_reg;

endmodule

[rtl/lpm_ctrl.sv]
// scan sequencer: walks the table one entry per cycle and hands off the result
// depends on lpm_pkg
module lpm_ctrl #(
    parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                out_free,
    output logic                ready,
    output logic [IDX_W-1:0]    rd_addr,
    output lpm_pkg::scan_ctrl_t ctrl
);
    import lpm_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl          = '0;
        ready         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    ctrl.clear = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.rd_en = 1'b1;
                ctrl.busy  = 1'b1;
                if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                // last read data is compared at this edge
                ctrl.busy  = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                ctrl.busy = 1'b1;
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign rd_addr = cnt_reg;

endmodule

[rtl/longest_prefix_match_lookup.sv]
// top level of the longest prefix match route lookup
// depends on lpm_pkg, lpm_table, lpm_best, lpm_ctrl
//
// input channel s_axis carries one item per handshake; tuser selects a
// table write or an address lookup. a write updates the entry at the edge
// that takes it and gives no result. a lookup reads the table memory one
// entry per cycle through a single compare unit, so the input stays closed
// through the scan (S_SCAN), the compare of the last entry (S_LAST) and the
// hand-off to the output register (S_REPORT); a new item is taken only
// once the sequencer is back in S_IDLE.
// the result sits in an output register; the block takes the next item
// while it waits, and a finished scan holds until that register is free,
// so a stalled receiver only delays the following lookup.
// reset empties the table (all valid flags cleared) and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module longest_prefix_match_lookup #(
    parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_slot, entry_enable, route_prefix_in, route_mask_in, route_port_in,
    // lookup_address, zero fill
    input  logic [lpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found, out_port, hit_slot, hit_mask, zero fill
    output logic [lpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import lpm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [SLOT_W-1:0] entry_slot;
    logic              entry_enable;
    logic [ADDR_W-1:0] route_prefix_in;
    logic [ADDR_W-1:0] route_mask_in;
    logic [PORT_W-1:0] route_port_in;
    logic [ADDR_W-1:0] lookup_address;

    logic              accept;
    logic              wr_en;
    logic              start;
    logic              out_free;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_strobe;
    logic [IDX_W-1:0]  rd_slot;
    entry_t            rd_entry;
    result_t           best;
    scan_ctrl_t        ctrl;

    logic              out_valid_reg;
    result_t           out_data_reg;

    assign entry_slot      = s_axis_tdata[3:0];
    assign entry_enable    = s_axis_tdata[4];
    assign route_prefix_in = s_axis_tdata[36:5];
    assign route_mask_in   = s_axis_tdata[68:37];
    assign route_port_in   = s_axis_tdata[72:69];
    assign lookup_address  = s_axis_tdata[104:73];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign start  = accept && (s_axis_tuser == CMD_LOOKUP);
    // out of range slot or port leaves the table untouched
    assign wr_en  = accept && (s_axis_tuser == CMD_WRITE)
                    && ({24'd0, entry_slot} < 28'(TABLE_DEPTH))
                    && ({24'd0, route_port_in} < 28'(PORT_COUNT));

    assign out_free = !out_valid_reg || m_axis_tready;

    lpm_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .ready    (s_axis_tready),
        .rd_addr  (rd_addr),
        .ctrl     (ctrl)
    );

    lpm_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_slot   (IDX_W'(entry_slot)),
        .wr_valid  (entry_enable),
        .wr_prefix (route_prefix_in),
        .wr_mask   (route_mask_in),
        .wr_port   (route_port_in),
        .rd_en     (ctrl.rd_en),
        .rd_addr   (rd_addr),
        .rd_strobe (rd_strobe),
        .rd_slot   (rd_slot),
        .rd_entry  (rd_entry)
    );

    lpm_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .clk            (clk),
        .clear          (ctrl.clear),
        .lookup_address (lookup_address),
        .rd_strobe      (rd_strobe),
        .rd_slot        (rd_slot),
        .rd_entry       (rd_entry),
        .best           (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg <= best;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_data_reg};

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> m_axis_tvalid)
        else $error("result not presented after load");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_data_reg.found |->
            out_data_reg.port == '0 && out_data_reg.slot == '0 && out_data_reg.mask == '0)
        else $error("miss result carries nonzero fields");

    a_scan_closed: assert property (@(posedge clk) disable iff (!rst_n)
        rd_strobe |-> !s_axis_tready)
        else $error("input open while table scan runs");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready && ctrl.busy)
        else $error("lookup accepted but scan did not start");
`endif

endmodule

[sim/longest_prefix_match_lookup_tb.sv]
// self-checking testbench for the longest prefix match route lookup
// depends on lpm_pkg and longest_prefix_match_lookup under rtl
// stream driver and monitor run against a route table predictor built into this file
module longest_prefix_match_lookup_tb;

    import lpm_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 135;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 40;

    typedef struct {
        logic        cmd;
        logic [3:0]  slot;
        logic        en;
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [3:0]  port;
        logic [31:0] addr;
        int          phase;
    } route_item_t;

    typedef struct {
        logic        found;
        logic [3:0]  port;
        logic [3:0]  slot;
        logic [31:0] mask;
    } route_hit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = CMD_WRITE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    route_item_t pend_q[$];
    route_hit_t  hit_q[$];
    route_item_t cur_item;
    int          total_items;
    int          accept_cnt = 0;
    int          phase_now = 0;
    int          gen_phase = 0;
    int          fail_cnt = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    // predictor copy of the routing table
    logic        rt_valid  [DEPTH];
    logic [31:0] rt_prefix [DEPTH];
    logic [31:0] rt_mask   [DEPTH];
    logic [3:0]  rt_port   [DEPTH];

    // generator's own view of what was written, only used to aim addresses
    logic [31:0] gen_prefix [DEPTH];
    logic [31:0] gen_mask   [DEPTH];

    longest_prefix_match_lookup #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sender_idle_pct(int ph);
        case (ph)
            1:       return 61;
            3:       return 31;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(int ph);
        case (ph)
            2:       return 61;
            3:       return 31;
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] prefix_mask(int unsigned len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // unused fields of each item carry random junk
    function automatic void add_write(logic [3:0] slot, logic en, logic [31:0] prefix,
                                      logic [31:0] mask, logic [3:0] port);
        route_item_t it;
        it.cmd    = CMD_WRITE;
        it.slot   = slot;
        it.en     = en;
        it.prefix = prefix;
        it.mask   = mask;
        it.port   = port;
        it.addr   = $urandom;
        it.phase  = gen_phase;
        pend_q.push_back(it);
        gen_prefix[slot] = prefix;
        gen_mask[slot]   = mask;
    endfunction

    function automatic void add_lookup(logic [31:0] addr);
        route_item_t it;
        it.cmd    = CMD_LOOKUP;
        it.slot   = 4'($urandom_range(15));
        it.en     = 1'($urandom_range(1));
        it.prefix = $urandom;
        it.mask   = $urandom;
        it.port   = 4'($urandom_range(15));
        it.addr   = addr;
        it.phase  = gen_phase;
        pend_q.push_back(it);
    endfunction

    // the numerically largest mask wins, ties go to the lowest slot
    function automatic route_hit_t best_route(logic [31:0] addr);
        route_hit_t r;
        r = '{found: 1'b0, port: 4'd0, slot: 4'd0, mask: 32'd0};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rt_valid[i] && ((rt_prefix[i] & rt_mask[i]) == (addr & rt_mask[i])))
            begin
                if (!r.found || rt_mask[i] > r.mask)
                begin
                    r.found = 1'b1;
                    r.port  = rt_port[i];
                    r.slot  = 4'(i);
                    r.mask  = rt_mask[i];
                end
            end
        end
        return r;
    endfunction

    function automatic void route_accept(route_item_t it);
        if (it.cmd == CMD_WRITE)
        begin
            if (it.slot < DEPTH && it.port < PORT_COUNT)
            begin
                rt_valid[it.slot]  = it.en;
                rt_prefix[it.slot] = it.prefix;
                rt_mask[it.slot]   = it.mask;
                rt_port[it.slot]   = it.port;
            end
        end
        else
        begin
            hit_q.push_back(best_route(it.addr));
        end
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                route_accept(cur_item);
                accept_cnt <= accept_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pend_q.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct(pend_q[0].phase))
                begin
                    cur_item = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.cmd;
                    s_tdata  <= {7'b0, cur_item.addr, cur_item.port, cur_item.mask,
                                 cur_item.prefix, cur_item.en, cur_item.slot};
                    phase_now <= cur_item.phase;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accept_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        route_hit_t got;
        route_hit_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found = m_tdata[0];
                got.port  = m_tdata[4:1];
                got.slot  = m_tdata[8:5];
                got.mask  = m_tdata[40:9];
                if (hit_q.size() == 0)
                begin
                    $error("result item with no lookup outstanding: %h", m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found mismatch: expected %0d, got %0d", want.found, got.found);
                        fail_cnt++;
                    end
                    if (got.port !== want.port)
                    begin
                        $error("out_port mismatch: expected %0d, got %0d", want.port, got.port);
                        fail_cnt++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $error("hit_slot mismatch: expected %0d, got %0d", want.slot, got.slot);
                        fail_cnt++;
                    end
                    if (got.mask !== want.mask)
                    begin
                        $error("hit_mask mismatch: expected %h, got %h", want.mask, got.mask);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct(phase_now));
        end
    end

    initial
    begin
        logic [3:0]  slot;
        logic [31:0] mask;
        logic [31:0] prefix;
        int          k;

        for (int i = 0; i < DEPTH; i++)
        begin
            rt_valid[i]   = 1'b0;
            rt_prefix[i]  = '0;
            rt_mask[i]    = '0;
            rt_port[i]    = '0;
            gen_prefix[i] = '0;
            gen_mask[i]   = '0;
        end

        // directed: empty table, default route, host route, ties, cleared entry
        gen_phase = 0;
        add_lookup(32'h0000_0000);
        add_write(4'd0, 1'b1, 32'hDEAD_BEEF, 32'h0, 4'd3);
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'h0000_0000);
        add_write(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'hFFFF_FFFE);
        add_write(4'd5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 4'd7);
        add_write(4'd3, 1'b1, 32'h0AFF_FFFF, 32'hFF00_0000, 4'd9);
        add_lookup(32'h0A12_3456);
        add_write(4'd3, 1'b0, 32'h0A00_0000, 32'hFF00_0000, 4'd9);
        add_lookup(32'h0A12_3456);
        add_write(4'd8, 1'b1, 32'h0A12_0000, 32'hFFFF_0000, 4'd1);
        add_lookup(32'h0A12_FFFF);
        add_lookup(32'h0A13_0000);
        // non-contiguous mask is compared bit for bit
        add_write(4'd10, 1'b1, 32'h5555_5555, 32'hF0F0_F0F0, 4'd12);
        add_lookup(32'h5F5F_5F5F);
        add_write(4'd0, 1'b0, 32'h0, 32'h0, 4'd0);
        add_lookup(32'h0000_0000);
        add_lookup(32'h8000_0000);
        add_write(4'd15, 1'b0, 32'h0, 32'hFFFF_FFFF, 4'd0);
        add_lookup(32'hFFFF_FFFF);

        for (int ph = 0; ph < 4; ph++)
        begin
            gen_phase = ph;
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                if ($urandom_range(99) < 30)
                begin
                    slot = 4'($urandom_range(15));
                    mask = ($urandom_range(99) < 10) ? $urandom : prefix_mask($urandom_range(32));
                    // reuse another entry's prefix now and then to set up ties and nesting
                    k = $urandom_range(15);
                    prefix = ($urandom_range(99) < 25) ? gen_prefix[k] : $urandom;
                    add_write(slot, $urandom_range(99) < 85, prefix, mask,
                              4'($urandom_range(15)));
                end
                else if ($urandom_range(99) < 75)
                begin
                    k = $urandom_range(15);
                    add_lookup((gen_prefix[k] & gen_mask[k]) | ($urandom & ~gen_mask[k]));
                end
                else
                begin
                    add_lookup($urandom);
                end
            end
        end
        total_items = pend_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accept_cnt != total_items)
            @(posedge clk);
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/lpm_pkg.sv
rtl/lpm_table.sv
rtl/lpm_best.sv
rtl/lpm_ctrl.sv
rtl/longest_prefix_match_lookup.sv
sim/longest_prefix_match_lookup_tb.sv
